### src/lru_page_replacement_assert.svh
// Assertion macros used by the block's checker.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define LRUPR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("lru_page_replacement: implication check failed");

// Next-cycle implication, disabled while reset is active.
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("lru_page_replacement: next-cycle check failed");

`endif

### src/lrupr_pkg.sv
// Shared types and defaults for the LRU page replacement block.
package lrupr_pkg;

	localparam int DEF_FRAMES    = 8;
	localparam int DEF_PAGE_BITS = 16;
	localparam logic [3:0] FRAME_COUNT_RESET = 4'd8;

	// Lookup token walking the cell row
	typedef struct packed {
		logic valid;
		logic found;
	} tok_t;

	// Update command broadcast to every cell
	typedef struct packed {
		logic en;
		logic hit;
	} upd_t;

endpackage

### src/lrupr_cell.sv
// One frame of the LRU row: page tag, recency rank and a lookup token stage.
module lrupr_cell
	import lrupr_pkg::*;
#(
	parameter int FRAMES    = DEF_FRAMES,
	parameter int PAGE_BITS = DEF_PAGE_BITS,
	parameter int IDX       = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [$clog2(FRAMES+1)-1:0] occ,
	input  logic [PAGE_BITS-1:0] page,
	input  tok_t tok_in,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] hidx_in,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] hage_in,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] lidx_in,
	input  logic [PAGE_BITS-1:0] ltag_in,
	output tok_t tok_out,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] hidx_out,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] hage_out,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] lidx_out,
	output logic [PAGE_BITS-1:0] ltag_out,
	input  upd_t upd,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] upd_idx,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] upd_limit
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES+1);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

	logic [PAGE_BITS-1:0] tag_q;
	logic [IDX_W-1:0]     age_q;
	logic                 filled;
	logic                 match;
	logic                 is_lru;
	logic [CNT_W-1:0]     occ_m1;

	tok_t                 tok_q;
	logic [IDX_W-1:0]     hidx_q;
	logic [IDX_W-1:0]     hage_q;
	logic [IDX_W-1:0]     lidx_q;
	logic [PAGE_BITS-1:0] ltag_q;

	assign filled = MY_CNT < occ;
	assign match  = filled && (tag_q == page);
	assign occ_m1 = occ - CNT_W'(1);
	assign is_lru = filled && (CNT_W'(age_q) == occ_m1);

	// token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found | match;
		end
	end

	always_ff @(posedge clk) begin
		hidx_q <= match ? MY_IDX : hidx_in;
		hage_q <= match ? age_q : hage_in;
		lidx_q <= is_lru ? MY_IDX : lidx_in;
		ltag_q <= is_lru ? tag_q : ltag_in;
	end

	// recency rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (upd.en) begin
			if (upd_idx == MY_IDX) begin
				age_q <= '0;
			end else if (filled && (!upd.hit || (age_q < upd_limit))) begin
				age_q <= age_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && !upd.hit && (upd_idx == MY_IDX)) begin
			tag_q <= page;
		end
	end

	assign tok_out  = tok_q;
	assign hidx_out = hidx_q;
	assign hage_out = hage_q;
	assign lidx_out = lidx_q;
	assign ltag_out = ltag_q;

endmodule

### src/lru_page_replacement.sv
// LRU page replacement unit: top level with request sequencer and frame cell row.
//
// Requests: one page reference per request on in_valid/in_ready with page.
// Results: one per request on out_valid/out_ready with hit, frame,
// evicted_valid, evicted_page and the saturating fault_count.
// frame_count is written through cfg_we/cfg_data, by the user only while the
// unit is idle (not enforced); 0 acts as 1 and values above FRAMES act as FRAMES.
// A lookup token walks the row of FRAMES cells, one cell per cycle, picking up
// the matching frame and the least recently used frame. The row is then
// updated at once, all cells in parallel, and out_valid rises with that update.
// One request is in flight at a time: a new request is not taken until the
// row update for the last one is done.
// The result sits in an output register; in_ready returns as soon as the
// update is done, so the next request may be taken while the result waits.
// If the previous result is still held when the update is due, the update
// waits until out_ready frees the output register.
// Reset empties all frames, clears ranks and the fault count, and sets
// frame_count to 8. No clearing pass is needed.
module lru_page_replacement
	import lrupr_pkg::*;
#(
	parameter int FRAMES    = DEF_FRAMES,
	parameter int PAGE_BITS = DEF_PAGE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PAGE_BITS-1:0] page,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [2:0]           frame,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [31:0]          fault_count
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES+1);
	localparam logic [CNT_W-1:0] FRAMES_CNT = CNT_W'(FRAMES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0]           state_q;
	logic [3:0]           fc_q;
	logic [CNT_W-1:0]     occ_q;
	logic [31:0]          faults_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 start_q;

	logic                 found_q;
	logic [IDX_W-1:0]     hidx_q;
	logic [IDX_W-1:0]     hage_q;
	logic [IDX_W-1:0]     lidx_q;
	logic [PAGE_BITS-1:0] ltag_q;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [2:0]           frame_q;
	logic                 ev_valid_q;
	logic [PAGE_BITS-1:0] ev_page_q;
	logic [31:0]          fault_q;

	tok_t                 tok   [0:FRAMES];
	logic [IDX_W-1:0]     hidx  [0:FRAMES];
	logic [IDX_W-1:0]     hage  [0:FRAMES];
	logic [IDX_W-1:0]     lidx  [0:FRAMES];
	logic [PAGE_BITS-1:0] ltag  [0:FRAMES];

	upd_t                 upd;
	logic [IDX_W-1:0]     upd_idx;
	logic [CNT_W-1:0]     cap;
	logic                 do_fill;
	logic                 fire;
	logic [31:0]          faults_nx;
	logic [IDX_W+2:0]     frame_ext;

	// capacity from frame_count
	always_comb begin
		if (fc_q == 4'd0) begin
			cap = CNT_W'(1);
		end else if (32'(fc_q) > FRAMES) begin
			cap = FRAMES_CNT;
		end else begin
			cap = CNT_W'(fc_q);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign fire      = (state_q == S_UPD) && (!out_valid_q || out_ready);
	assign do_fill   = !found_q && (occ_q < cap);
	assign upd_idx   = found_q ? hidx_q : (do_fill ? occ_q[IDX_W-1:0] : lidx_q);
	assign upd.en    = fire;
	assign upd.hit   = found_q;
	assign faults_nx = (found_q || (&faults_q)) ? faults_q : faults_q + 32'd1;
	assign frame_ext = {3'b000, upd_idx};

	assign tok[0].valid = start_q;
	assign tok[0].found = 1'b0;
	assign hidx[0]      = '0;
	assign hage[0]      = '0;
	assign lidx[0]      = '0;
	assign ltag[0]      = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lrupr_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.IDX       (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.occ       (occ_q),
			.page      (page_q),
			.tok_in    (tok[i]),
			.hidx_in   (hidx[i]),
			.hage_in   (hage[i]),
			.lidx_in   (lidx[i]),
			.ltag_in   (ltag[i]),
			.tok_out   (tok[i+1]),
			.hidx_out  (hidx[i+1]),
			.hage_out  (hage[i+1]),
			.lidx_out  (lidx[i+1]),
			.ltag_out  (ltag[i+1]),
			.upd       (upd),
			.upd_idx   (upd_idx),
			.upd_limit (hage_q)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= FRAME_COUNT_RESET;
		end else if (cfg_we) begin
			fc_q <= cfg_data;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			occ_q       <= '0;
			faults_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= (state_q == S_IDLE) && in_valid;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (tok[FRAMES].valid) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (fire) begin
						if (do_fill) begin
							occ_q <= occ_q + CNT_W'(1);
						end
						faults_q <= faults_nx;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_q <= page;
		end
		if ((state_q == S_WALK) && tok[FRAMES].valid) begin
			found_q <= tok[FRAMES].found;
			hidx_q  <= hidx[FRAMES];
			hage_q  <= hage[FRAMES];
			lidx_q  <= lidx[FRAMES];
			ltag_q  <= ltag[FRAMES];
		end
		if (fire) begin
			hit_q      <= found_q;
			frame_q    <= frame_ext[2:0];
			ev_valid_q <= !found_q && !do_fill;
			ev_page_q  <= (!found_q && !do_fill) ? ltag_q : '0;
			fault_q    <= faults_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame         = frame_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_count   = fault_q;

endmodule

### src/lrupr_checker.sv
// Port-level checks for the LRU page replacement block, bound to the top level.
`include "lru_page_replacement_assert.svh"

module lrupr_checker
	import lrupr_pkg::*;
#(
	parameter int PAGE_BITS = DEF_PAGE_BITS
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 hit,
	input logic [2:0]           frame,
	input logic                 evicted_valid,
	input logic [PAGE_BITS-1:0] evicted_page,
	input logic [31:0]          fault_count
);

	// stalled result holds
	`LRUPR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hit) && $stable(frame) && $stable(evicted_valid) && $stable(evicted_page) && $stable(fault_count))

	// one request in flight
	`LRUPR_ASSERT_NEXT(a_one_inflight, clk, arst_n, in_valid && in_ready, !in_ready)

	// a new result only follows a request in progress
	`LRUPR_ASSERT_IMPLY(a_out_after_req, clk, arst_n, $rose(out_valid), !$past(in_ready))

	// eviction is a fault and is counted
	`LRUPR_ASSERT_IMPLY(a_evict_fault, clk, arst_n, out_valid && evicted_valid, !hit && (fault_count != 32'd0))

endmodule

bind lru_page_replacement lrupr_checker #(.PAGE_BITS(PAGE_BITS)) u_lrupr_checker (.*);
